// ===== rtl/core/pmfc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the pausable media frame clock.
package pmfc_pkg;

    localparam int unsigned TICK_W   = 64;
    localparam int unsigned RATE_W   = 32;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [MODE_W-1:0] MODE_OBSERVE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PAUSE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESUME  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEEK    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_HZ     = 1'd1;

    localparam logic [RATE_W-1:0] SAMPLE_RATE_RESET = 32'd48000;
    localparam logic [RATE_W-1:0] TICK_HZ_RESET     = 32'd10000000;

    localparam int unsigned MUL_STEPS = RATE_W;
    localparam int unsigned DIV_STEPS = TICK_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TICK_W-1:0] now_ticks;
        logic [TICK_W-1:0] seek_frame;
    } pmfc_in_t;

    typedef struct packed {
        logic [TICK_W-1:0] frame_count;
        logic [TICK_W-1:0] source_position;
        logic              reading_valid;
        logic              is_paused;
    } pmfc_out_t;

    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] ticks;
        logic [RATE_W-1:0] mul;
        logic [RATE_W-1:0] div;
    } pmfc_arith_req_t;

    typedef struct packed {
        logic              done;
        logic [TICK_W-1:0] quot;
    } pmfc_arith_rsp_t;

endpackage

// ===== rtl/core/pausable_media_frame_clock_core.sv =====
`timescale 1ns / 1ps
// Top level of the pausable media frame clock with its rate registers.
// An item runs through the shift-add multiply and restoring divide when a count is computed, and
// skips them when the count is zero (not started, zero tick rate or no elapsed time).
// The 32 multiply steps and 64 divide steps run on one shared adder.
// One item is in work at a time, so a new item is taken only after the last one's result is registered.
// Reset is asynchronous and active low; it clears the clock state and loads the default rates.
module pausable_media_frame_clock_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pmfc_pkg::pmfc_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pmfc_pkg::pmfc_out_t            out_data,
    input  logic                           cfg_we,
    input  logic [pmfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pmfc_pkg::RATE_W-1:0]    cfg_data
);
    import pmfc_pkg::*;

    logic [RATE_W-1:0] sample_rate_reg;
    logic [RATE_W-1:0] tick_hz_reg;
    pmfc_arith_req_t   arith_req;
    pmfc_arith_rsp_t   arith_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= SAMPLE_RATE_RESET;
            tick_hz_reg     <= TICK_HZ_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SAMPLE_RATE: sample_rate_reg <= cfg_data;
                CFG_TICK_HZ:     tick_hz_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    pmfc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .sample_rate (sample_rate_reg),
        .tick_hz     (tick_hz_reg),
        .arith_req   (arith_req),
        .arith_rsp   (arith_rsp)
    );

    pmfc_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (arith_req),
        .rsp   (arith_rsp)
    );

endmodule

// ===== rtl/core/pmfc_arith.sv =====
`timescale 1ns / 1ps
// Shift-add multiplier and restoring divider that share one 64-bit adder.
module pmfc_arith (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pmfc_pkg::pmfc_arith_req_t req,
    output pmfc_pkg::pmfc_arith_rsp_t rsp
);
    import pmfc_pkg::*;

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV
    } arith_state_t;

    arith_state_t      state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TICK_W-1:0] acc_reg, acc_next;
    logic [TICK_W-1:0] mcand_reg, mcand_next;
    logic [RATE_W-1:0] mplier_reg, mplier_next;
    logic [RATE_W-1:0] rem_reg, rem_next;
    logic [RATE_W-1:0] div_reg, div_next;
    logic              done_reg, done_next;

    logic [TICK_W-1:0] add_x, add_y;
    logic              add_cin;
    logic [TICK_W:0]   add_sum;
    logic [RATE_W:0]   rem_shift;

    assign rem_shift = {rem_reg, acc_reg[TICK_W-1]};

    always_comb
    begin
        if (state_reg == A_DIV)
        begin
            add_x   = {{(TICK_W-RATE_W-1){1'b0}}, rem_shift};
            add_y   = ~{{(TICK_W-RATE_W){1'b0}}, div_reg};
            add_cin = 1'b1;
        end
        else
        begin
            add_x   = acc_reg;
            add_y   = mplier_reg[0] ? mcand_reg : '0;
            add_cin = 1'b0;
        end
        add_sum = {1'b0, add_x} + {1'b0, add_y} + {{TICK_W{1'b0}}, add_cin};
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        done_next   = 1'b0;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    acc_next    = '0;
                    mcand_next  = req.ticks;
                    mplier_next = req.mul;
                    div_next    = req.div;
                    cnt_next    = '0;
                    state_next  = A_MUL;
                end
            end
            A_MUL:
            begin
                acc_next    = add_sum[TICK_W-1:0];
                mcand_next  = {mcand_reg[TICK_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[RATE_W-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = A_DIV;
                end
            end
            A_DIV:
            begin
                rem_next = add_sum[TICK_W] ? add_sum[RATE_W-1:0] : rem_shift[RATE_W-1:0];
                acc_next = {acc_reg[TICK_W-2:0], add_sum[TICK_W]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = acc_reg;

endmodule

// ===== rtl/core/pmfc_ctrl.sv =====
`timescale 1ns / 1ps
// Event sequencer, clock state and result register of the frame clock.
module pmfc_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  pmfc_pkg::pmfc_in_t        in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output pmfc_pkg::pmfc_out_t       out_data,
    input  logic [pmfc_pkg::RATE_W-1:0] sample_rate,
    input  logic [pmfc_pkg::RATE_W-1:0] tick_hz,
    output pmfc_pkg::pmfc_arith_req_t arith_req,
    input  pmfc_pkg::pmfc_arith_rsp_t arith_rsp
);
    import pmfc_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE,
        C_APPLY,
        C_HELD,
        C_SPENT,
        C_DIFF,
        C_ARITH,
        C_ANCHOR,
        C_DELTA,
        C_POS
    } ctrl_state_t;

    ctrl_state_t       state_reg, state_next;
    logic              started_reg, started_next;
    logic              paused_reg, paused_next;
    logic [TICK_W-1:0] start_tick_reg, start_tick_next;
    logic [TICK_W-1:0] held_reg, held_next;
    logic [TICK_W-1:0] pause_tick_reg, pause_tick_next;
    logic [TICK_W-1:0] anc_dev_reg, anc_dev_next;
    logic [TICK_W-1:0] anc_src_reg, anc_src_next;
    pmfc_in_t          item_reg, item_next;
    logic [TICK_W-1:0] tmp_reg, tmp_next;
    logic              gt_reg, gt_next;
    logic [TICK_W-1:0] count_reg, count_next;
    logic              go_reg, go_next;
    logic              out_valid_reg, out_valid_next;
    pmfc_out_t         out_reg, out_next;

    logic [TICK_W:0]   sub_res;
    logic [TICK_W-1:0] sub_a, sub_b;
    logic [TICK_W-1:0] now_eff;

    assign now_eff = paused_reg ? pause_tick_reg : item_reg.now_ticks;

    always_comb
    begin
        case (state_reg)
            C_APPLY:
            begin
                sub_a = item_reg.now_ticks;
                sub_b = pause_tick_reg;
            end
            C_DIFF:
            begin
                sub_a = now_eff;
                sub_b = tmp_reg;
            end
            default:
            begin
                sub_a = count_reg;
                sub_b = anc_dev_reg;
            end
        endcase
        sub_res = {1'b0, sub_a} - {1'b0, sub_b};
    end

    always_comb
    begin
        state_next      = state_reg;
        started_next    = started_reg;
        paused_next     = paused_reg;
        start_tick_next = start_tick_reg;
        held_next       = held_reg;
        pause_tick_next = pause_tick_reg;
        anc_dev_next    = anc_dev_reg;
        anc_src_next    = anc_src_reg;
        item_next       = item_reg;
        tmp_next        = tmp_reg;
        gt_next         = gt_reg;
        count_next      = count_reg;
        go_next         = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = C_APPLY;
                end
            end
            C_APPLY:
            begin
                tmp_next = sub_res[TICK_W-1:0];
                gt_next  = !sub_res[TICK_W] && (sub_res[TICK_W-1:0] != '0);
                case (item_reg.mode)
                    MODE_START:
                    begin
                        start_tick_next = item_reg.now_ticks;
                        held_next       = '0;
                        paused_next     = 1'b0;
                        started_next    = 1'b1;
                    end
                    MODE_PAUSE:
                    begin
                        if (started_reg && !paused_reg)
                        begin
                            pause_tick_next = item_reg.now_ticks;
                            paused_next     = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = C_HELD;
            end
            C_HELD:
            begin
                if (item_reg.mode == MODE_RESUME && paused_reg)
                begin
                    if (gt_reg)
                    begin
                        held_next = held_reg + tmp_reg;
                    end
                    paused_next = 1'b0;
                end
                state_next = C_SPENT;
            end
            C_SPENT:
            begin
                tmp_next   = start_tick_reg + held_reg;
                state_next = C_DIFF;
            end
            C_DIFF:
            begin
                if (!started_reg || tick_hz == '0 || sub_res[TICK_W]
                    || sub_res[TICK_W-1:0] == '0)
                begin
                    count_next = '0;
                    state_next = C_ANCHOR;
                end
                else
                begin
                    tmp_next   = sub_res[TICK_W-1:0];
                    go_next    = 1'b1;
                    state_next = C_ARITH;
                end
            end
            C_ARITH:
            begin
                if (arith_rsp.done)
                begin
                    count_next = arith_rsp.quot;
                    state_next = C_ANCHOR;
                end
            end
            C_ANCHOR:
            begin
                if (item_reg.mode == MODE_SEEK)
                begin
                    anc_dev_next = count_reg;
                    anc_src_next = item_reg.seek_frame;
                end
                state_next = C_DELTA;
            end
            C_DELTA:
            begin
                tmp_next   = sub_res[TICK_W] ? '0 : sub_res[TICK_W-1:0];
                state_next = C_POS;
            end
            C_POS:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.frame_count     = count_reg;
                    out_next.source_position = anc_src_reg + tmp_reg;
                    out_next.reading_valid   = started_reg;
                    out_next.is_paused       = paused_reg;
                    out_valid_next           = 1'b1;
                    state_next               = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= C_IDLE;
            started_reg    <= 1'b0;
            paused_reg     <= 1'b0;
            start_tick_reg <= '0;
            held_reg       <= '0;
            pause_tick_reg <= '0;
            anc_dev_reg    <= '0;
            anc_src_reg    <= '0;
            go_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            started_reg    <= started_next;
            paused_reg     <= paused_next;
            start_tick_reg <= start_tick_next;
            held_reg       <= held_next;
            pause_tick_reg <= pause_tick_next;
            anc_dev_reg    <= anc_dev_next;
            anc_src_reg    <= anc_src_next;
            go_reg         <= go_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        tmp_reg   <= tmp_next;
        gt_reg    <= gt_next;
        count_reg <= count_next;
        out_reg   <= out_next;
    end

    assign in_ready        = (state_reg == C_IDLE);
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;
    assign arith_req.start = go_reg;
    assign arith_req.ticks = tmp_reg;
    assign arith_req.mul   = sample_rate;
    assign arith_req.div   = tick_hz;

endmodule

// ===== rtl/core/pmfc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the frame clock and its bind to the top level.
module pmfc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input pmfc_pkg::pmfc_in_t             in_data,
    input logic                           out_valid,
    input logic                           out_ready,
    input pmfc_pkg::pmfc_out_t            out_data
);
    import pmfc_pkg::*;

    // A stalled input beat holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input beat changed while stalled");

    // A stalled result beat holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // The block is busy on the cycle after it takes an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    // A clock that was never started counts nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.reading_valid |-> out_data.frame_count == '0)
        else $error("frames counted before start");

    // Only a started clock can be paused.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_paused |-> out_data.reading_valid)
        else $error("paused flag without start");

endmodule

bind pausable_media_frame_clock_core pmfc_checker u_pmfc_checker (.*);

// ===== bench/pausable_media_frame_clock_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the pausable media frame clock core.
module pausable_media_frame_clock_core_tb;
    import pmfc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNDEF_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 3'd7;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 120;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 130;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    pmfc_in_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    pmfc_out_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RATE_W-1:0]    cfg_data;

    logic [RATE_W-1:0] rate_sample   = SAMPLE_RATE_RESET;
    logic [RATE_W-1:0] rate_tick     = TICK_HZ_RESET;
    logic              clk_running   = 1'b0;
    logic              clk_paused    = 1'b0;
    logic [TICK_W-1:0] start_at      = '0;
    logic [TICK_W-1:0] held_total    = '0;
    logic [TICK_W-1:0] paused_at     = '0;
    logic [TICK_W-1:0] anchor_frames = '0;
    logic [TICK_W-1:0] anchor_source = '0;

    pmfc_out_t expected_readings[$];
    int        mismatch_count = 0;
    int        idle_pct = 0;
    int        stall_left = 0;
    int        quiet_cycles = 0;

    pausable_media_frame_clock_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [TICK_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [TICK_W-1:0] tick_step();
        logic [TICK_W-1:0] span;
        span = rand64();
        return span >> $urandom_range(24, 63);
    endfunction

    function automatic logic [TICK_W-1:0] frames_at(input logic [TICK_W-1:0] now_in);
        logic [TICK_W-1:0] ref_tick;
        logic [TICK_W-1:0] spent;
        logic [TICK_W-1:0] scaled;
        if (!clk_running || rate_tick == '0)
        begin
            return '0;
        end
        ref_tick = clk_paused ? paused_at : now_in;
        spent = start_at + held_total;
        if (ref_tick <= spent)
        begin
            return '0;
        end
        scaled = (ref_tick - spent) * {32'd0, rate_sample};
        return scaled / {32'd0, rate_tick};
    endfunction

    function automatic pmfc_out_t predict_reading(input pmfc_in_t beat);
        pmfc_out_t         reading;
        logic [TICK_W-1:0] count;
        case (beat.mode)
            MODE_START:
            begin
                start_at = beat.now_ticks;
                held_total = '0;
                clk_paused = 1'b0;
                clk_running = 1'b1;
            end
            MODE_PAUSE:
            begin
                if (clk_running && !clk_paused)
                begin
                    paused_at = beat.now_ticks;
                    clk_paused = 1'b1;
                end
            end
            MODE_RESUME:
            begin
                if (clk_paused)
                begin
                    if (beat.now_ticks > paused_at)
                    begin
                        held_total = held_total + (beat.now_ticks - paused_at);
                    end
                    clk_paused = 1'b0;
                end
            end
            MODE_SEEK:
            begin
                anchor_frames = frames_at(beat.now_ticks);
                anchor_source = beat.seek_frame;
            end
            default:
            begin
            end
        endcase
        count = frames_at(beat.now_ticks);
        reading.frame_count = count;
        reading.source_position = anchor_source +
                                  ((count > anchor_frames) ? count - anchor_frames : '0);
        reading.reading_valid = clk_running;
        reading.is_paused = clk_paused;
        return reading;
    endfunction

    task automatic report_mismatch(input string what, input pmfc_out_t want,
                                   input pmfc_out_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t %s: exp frames=%0h pos=%0h valid=%0b paused=%0b", $realtime, what,
                     want.frame_count, want.source_position, want.reading_valid,
                     want.is_paused);
            $display("    got frames=%0h pos=%0h valid=%0b paused=%0b",
                     got.frame_count, got.source_position, got.reading_valid,
                     got.is_paused);
        end
    endtask

    always @(posedge clk)
    begin
        pmfc_out_t want;
        if (out_valid && out_ready)
        begin
            if (expected_readings.size() == 0)
            begin
                report_mismatch("unexpected reading", '0, out_data);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (out_data.frame_count !== want.frame_count ||
                    out_data.source_position !== want.source_position ||
                    out_data.reading_valid !== want.reading_valid ||
                    out_data.is_paused !== want.is_paused)
                begin
                    report_mismatch("wrong reading", want, out_data);
                end
            end
        end
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct / 4)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("pausable_media_frame_clock_core: mismatch");
            $finish;
        end
    end

    task automatic send_event(input logic [MODE_W-1:0] mode, input logic [TICK_W-1:0] now,
                              input logic [TICK_W-1:0] frame);
        pmfc_in_t beat;
        beat.mode = mode;
        beat.now_ticks = now;
        beat.seek_frame = frame;
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        expected_readings.push_back(predict_reading(beat));
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic drain_readings();
        if (in_valid)
        begin
            in_valid <= 1'b0;
        end
        while (expected_readings.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_rates(input logic [RATE_W-1:0] sample, input logic [RATE_W-1:0] ticks);
        drain_readings();
        cfg_we <= 1'b1;
        cfg_index <= CFG_SAMPLE_RATE;
        cfg_data <= sample;
        @(posedge clk);
        rate_sample = sample;
        cfg_index <= CFG_TICK_HZ;
        cfg_data <= ticks;
        @(posedge clk);
        rate_tick = ticks;
        cfg_we <= 1'b0;
    endtask

    task automatic test_unstarted_events();
        send_event(MODE_OBSERVE, '0, '0);
        send_event(MODE_PAUSE, 64'd100, '0);
        send_event(MODE_RESUME, 64'd200, '0);
        send_event(MODE_SEEK, 64'd300, '1);
        send_event(MODE_UNDEF_LO, '1, '1);
        send_event(MODE_UNDEF_HI, 64'd400, '0);
    endtask

    task automatic test_pause_resume_seek();
        send_event(MODE_START, 64'd1000, '0);
        send_event(MODE_OBSERVE, 64'd1000, '0);
        send_event(MODE_OBSERVE, 64'd500, '0);
        send_event(MODE_OBSERVE, 64'd10_001_000, '0);
        send_event(MODE_SEEK, 64'd20_001_000, 64'd5);
        send_event(MODE_PAUSE, 64'd30_001_000, '0);
        send_event(MODE_PAUSE, 64'd40_001_000, '0);
        send_event(MODE_OBSERVE, '1, '0);
        send_event(MODE_SEEK, 64'd45_000_000, '0);
        send_event(MODE_RESUME, 64'd25_001_000, '0);
        send_event(MODE_PAUSE, 64'd50_001_000, '0);
        send_event(MODE_RESUME, 64'd60_001_000, '0);
        send_event(MODE_OBSERVE, '1, '0);
        send_event(MODE_START, '1, '0);
        send_event(MODE_OBSERVE, '0, '0);
        send_event(MODE_UNDEF_HI - 3'd1, '1, '0);
    endtask

    task automatic test_rate_extremes();
        set_rates(SAMPLE_RATE_RESET, '0);
        send_event(MODE_START, 64'd5, '0);
        send_event(MODE_OBSERVE, '1, '0);
        set_rates('1, 32'd1);
        send_event(MODE_START, '0, '0);
        send_event(MODE_OBSERVE, '1, '0);
        send_event(MODE_SEEK, 64'h8000_0000_0000_0000, '1);
        set_rates('0, '1);
        send_event(MODE_OBSERVE, '1, '0);
        set_rates('1, '1);
        send_event(MODE_OBSERVE, 64'h1234_5678_9ABC_DEF0, '0);
    endtask

    task automatic test_random_traffic();
        logic [RATE_W-1:0] sample_sel;
        logic [RATE_W-1:0] tick_sel;
        logic [TICK_W-1:0] cursor;
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] frame;
        logic [MODE_W-1:0] mode;
        int                pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: begin sample_sel = SAMPLE_RATE_RESET; tick_sel = TICK_HZ_RESET; end
                1: begin sample_sel = 32'd44100; tick_sel = 32'd1_000_000; end
                2: begin sample_sel = '1; tick_sel = 32'd1; end
                3: begin sample_sel = 32'd1; tick_sel = '1; end
                4: begin sample_sel = '1; tick_sel = '1; end
                5: begin sample_sel = '0; tick_sel = 32'd12345; end
                6: begin sample_sel = 32'd96000; tick_sel = '0; end
                7, 8: begin sample_sel = $urandom; tick_sel = $urandom >> $urandom_range(0, 31); end
                default: begin sample_sel = SAMPLE_RATE_RESET; tick_sel = TICK_HZ_RESET; end
            endcase
            set_rates(sample_sel, tick_sel);
            case ($urandom_range(0, 3))
                0: idle_pct = 0;
                1: idle_pct = 15;
                2: idle_pct = 40;
                default: idle_pct = 70;
            endcase
            if (phase == RANDOM_PHASES - 1)
            begin
                idle_pct = 0;
            end
            case ($urandom_range(0, 2))
                0: cursor = '0;
                1: cursor = rand64();
                default: cursor = '1 - tick_step();
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 199) == 0)
                begin
                    drain_readings();
                end
                frame = $urandom_range(0, 1) ? rand64() : tick_step();
                if ($urandom_range(0, 9) == 0)
                begin
                    mode = MODE_W'($urandom_range(0, 7));
                    send_event(mode, rand64(), rand64());
                end
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (!clk_running || pick < 6)
                        mode = MODE_START;
                    else if (pick < 40)
                        mode = MODE_OBSERVE;
                    else if (pick < 55)
                        mode = MODE_PAUSE;
                    else if (pick < 70)
                        mode = MODE_RESUME;
                    else if (pick < 88)
                        mode = MODE_SEEK;
                    else
                        mode = MODE_W'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
                    if ($urandom_range(0, 99) < 8)
                    begin
                        now = cursor - tick_step();
                    end
                    else
                    begin
                        cursor = cursor + tick_step();
                        now = cursor;
                    end
                    send_event(mode, now, frame);
                end
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        out_ready <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        idle_pct = 30;
        test_unstarted_events();
        test_pause_resume_seek();
        test_rate_extremes();
        test_random_traffic();
        drain_readings();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_readings.size() == 0)
        begin
            $display("pausable_media_frame_clock_core: match");
        end
        else
        begin
            $display("pausable_media_frame_clock_core: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pmfc_pkg.sv
rtl/core/pmfc_arith.sv
rtl/core/pmfc_ctrl.sv
rtl/core/pausable_media_frame_clock_core.sv
rtl/core/pmfc_checker.sv
bench/pausable_media_frame_clock_core_tb.sv
